// ----- src/lphm_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the linear probing hash map.
// Used by the interfaces' users, the controller, the datapath and the top level.
package lphm_pkg;

  localparam int LOG_SLOTS_MAX = 12;
  localparam logic [3:0] SIZE_LOG_RST = 4'd12;
  localparam int PADDR_W = 3;
  localparam logic [31:0] HASH_MUL = 32'd2654435761;
  localparam logic [31:0] EMPTY_VAL = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    ACT_ACCESS = 2'd0,
    ACT_WRITE  = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_RESERVED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    WS_SWEEP  = 2'd0,
    WS_INSERT = 2'd1,
    WS_MOVE   = 2'd2,
    WS_VACATE = 2'd3
  } wsel_t;

  typedef enum logic [1:0] {
    RES_FREE     = 2'd0,
    RES_HIT      = 2'd1,
    RES_FULL     = 2'd2,
    RES_RESERVED = 2'd3
  } res_sel_t;

  typedef struct packed {
    logic     accept;
    logic     probe_start;
    logic     probe_next;
    logic     shift_start;
    logic     shift_load;
    logic     shift_eval;
    logic     shift_next;
    logic     sweep;
    logic     wr_en;
    wsel_t    wsel;
    logic     finish;
    res_sel_t res_sel;
    logic     emit;
  } cmd_t;

  typedef struct packed {
    action_t op;
    logic    reserved;
    logic    empty;
    logic    match;
    logic    last;
    logic    move;
    logic    sweep_last;
    logic    out_free;
  } stat_t;

endpackage

// ----- src/lphm_ifs.sv -----
`timescale 1ns / 1ps
// Request and response channel interfaces of the hash map.
// Each carries valid, ready and the transaction payload; no dependencies.
interface lphm_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] key;
  logic [31:0] data;

  modport source (output valid, action, key, data, input ready);
  modport sink (input valid, action, key, data, output ready);
endinterface

interface lphm_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic        found;
  logic [1:0]  status;

  modport source (output valid, value, found, status, input ready);
  modport sink (input valid, value, found, status, output ready);
endinterface

// ----- src/linear_probe_hash_map.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Payload
// req       in         action, key, data
// rsp       out        value, found, status
// apb       in/out     size_log register at byte address 0
//
// Access and write probe slot after slot; every slot visit is a read of the slot RAM
// (one write port, one read port) followed by a compare. Remove of a present key then runs a
// shift-back pass that reads, checks and evaluates each occupied slot scanned (SREAD, SCHK,
// SHOME) and ends with the vacate write (SFIN), at an empty slot or after the last slot in use.
// Clear and the clearing pass after reset sweep all 2^LOG_SLOTS slots, one slot per cycle; no
// request is taken meanwhile, but register writes are.
// A pending response does not block the next request; it only holds the final emit step.
// Top level of the hash map; depends on lphm_pkg, lphm_ifs, lphm_ctrl and lphm_dpath.
module linear_probe_hash_map import lphm_pkg::*; #(
  parameter int LOG_SLOTS = LOG_SLOTS_MAX
) (
  input  logic               clk,
  input  logic               rst,
  lphm_req_if.sink           req,
  lphm_rsp_if.source         rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [3:0] size_log;
  cmd_t       cmd;
  stat_t      stat;
  status_t    out_status;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {28'd0, size_log};

  always_ff @(posedge clk) begin
    if (rst) begin
      size_log <= SIZE_LOG_RST;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      size_log <= pwdata[3:0];
    end
  end

  lphm_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(req.valid),
    .in_ready(req.ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  lphm_dpath #(
    .LOG_SLOTS(LOG_SLOTS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .size_log  (size_log),
    .in_action (action_t'(req.action)),
    .in_key    (req.key),
    .in_data   (req.data),
    .out_ready (rsp.ready),
    .out_valid (rsp.valid),
    .out_value (rsp.value),
    .out_found (rsp.found),
    .out_status(out_status)
  );

  assign rsp.status = out_status;

`ifndef NO_ASSERTIONS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request accepted while a transaction is in progress");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> stat.out_free)
    else $error("response emitted over an untaken response");

  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_en |-> !req.ready)
    else $error("slot write while idle");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.found |-> rsp.status == STAT_OK)
    else $error("found key reported with an error status");
`endif

endmodule

// ----- src/lphm_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module lphm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/lphm_dpath.sv -----
`timescale 1ns / 1ps
// Datapath of the hash map: slot RAM, hash multiplier, probe and shift counters, result registers.
// Depends on lphm_pkg and lphm_ram.
module lphm_dpath import lphm_pkg::*; #(
  parameter int LOG_SLOTS = LOG_SLOTS_MAX
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic [3:0]  size_log,
  input  action_t     in_action,
  input  logic [31:0] in_key,
  input  logic [31:0] in_data,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [31:0] out_value,
  output logic        out_found,
  output status_t     out_status
);

  localparam int LG_W = $clog2(LOG_SLOTS + 1);
  localparam int DEPTH = 1 << LOG_SLOTS;

  logic [LG_W-1:0]      lg;
  logic [LOG_SLOTS:0]   span;
  logic [LOG_SLOTS-1:0] mask;
  logic [31:0]          prod;
  logic [31:0]          prod_next;
  logic [31:0]          mul_a;
  logic [31:0]          home_full;
  logic [LOG_SLOTS-1:0] home;
  logic [LOG_SLOTS-1:0] idx;
  logic [LOG_SLOTS-1:0] idx_inc;
  logic [LOG_SLOTS-1:0] hole;
  logic [LOG_SLOTS-1:0] shift_gap;
  logic [LOG_SLOTS-1:0] n;
  logic [LOG_SLOTS-1:0] cnt;
  logic [LOG_SLOTS-1:0] offset;
  action_t              op;
  logic [31:0]          key_r;
  logic [31:0]          data_r;
  logic [31:0]          res_value;
  logic                 res_found;
  status_t              res_status;
  logic [63:0]          rdata;
  logic [31:0]          rd_key;
  logic [31:0]          rd_val;
  logic [LOG_SLOTS-1:0] waddr;
  logic [63:0]          wdata;

  always_comb begin
    if (size_log == 4'd0) begin
      lg = LG_W'(1);
    end else if (int'(size_log) > LOG_SLOTS) begin
      lg = LG_W'(LOG_SLOTS);
    end else begin
      lg = LG_W'(size_log);
    end
  end

  assign span = (LOG_SLOTS + 1)'(1) << lg;
  assign mask = LOG_SLOTS'(span - 1'b1);

  assign rd_key = rdata[63:32];
  assign rd_val = rdata[31:0];
  assign mul_a = cmd.accept ? in_key : rd_key;
  assign prod_next = 32'(mul_a * HASH_MUL);
  assign home_full = prod >> (6'd32 - 6'(lg));
  assign home = home_full[LOG_SLOTS-1:0];
  assign idx_inc = (idx + 1'b1) & mask;
  assign offset = (idx - home) & mask;

  assign stat.op = op;
  assign stat.reserved = (data_r == EMPTY_VAL);
  assign stat.empty = (rd_val == EMPTY_VAL);
  assign stat.match = (rd_key == key_r);
  assign stat.last = (n == mask);
  assign stat.move = (offset >= shift_gap);
  assign stat.sweep_last = (cnt == {LOG_SLOTS{1'b1}});
  assign stat.out_free = !out_valid || out_ready;

  always_comb begin
    case (cmd.wsel)
      WS_SWEEP: begin
        waddr = cnt;
        wdata = {32'd0, EMPTY_VAL};
      end
      WS_INSERT: begin
        waddr = idx;
        wdata = {key_r, (op == ACT_WRITE) ? data_r : 32'd0};
      end
      WS_MOVE: begin
        waddr = hole;
        wdata = rdata;
      end
      WS_VACATE: begin
        waddr = hole;
        wdata = {rd_key, EMPTY_VAL};
      end
      default: begin
        waddr = cnt;
        wdata = {32'd0, EMPTY_VAL};
      end
    endcase
  end

  lphm_ram #(
    .WIDTH(64),
    .DEPTH(DEPTH)
  ) u_slots (
    .clk  (clk),
    .we   (cmd.wr_en),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(idx),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.accept || cmd.shift_load) begin
      prod <= prod_next;
    end
    if (cmd.accept) begin
      op <= in_action;
      key_r <= in_key;
      data_r <= in_data;
    end

    if (cmd.probe_start) begin
      idx <= home;
    end else if (cmd.probe_next || cmd.shift_start || cmd.shift_next) begin
      idx <= idx_inc;
    end

    if (cmd.probe_start) begin
      n <= '0;
    end else if (cmd.shift_start) begin
      n <= LOG_SLOTS'(1);
    end else if (cmd.probe_next || cmd.shift_next) begin
      n <= n + 1'b1;
    end

    if (cmd.shift_start) begin
      hole <= idx;
      shift_gap <= LOG_SLOTS'(1);
    end else if (cmd.shift_eval) begin
      if (stat.move) begin
        hole <= idx;
        shift_gap <= LOG_SLOTS'(1);
      end else begin
        shift_gap <= shift_gap + 1'b1;
      end
    end

    if (cmd.accept) begin
      res_value <= '0;
      res_found <= 1'b0;
      res_status <= STAT_OK;
    end else if (cmd.finish) begin
      case (cmd.res_sel)
        RES_FREE: begin
          res_value <= (op == ACT_WRITE) ? data_r : 32'd0;
          res_found <= 1'b0;
          res_status <= STAT_OK;
        end
        RES_HIT: begin
          res_value <= (op == ACT_WRITE) ? data_r : rd_val;
          res_found <= 1'b1;
          res_status <= STAT_OK;
        end
        RES_FULL: begin
          res_value <= '0;
          res_found <= 1'b0;
          res_status <= STAT_FULL;
        end
        RES_RESERVED: begin
          res_value <= '0;
          res_found <= 1'b0;
          res_status <= STAT_RESERVED;
        end
        default: begin
          res_value <= '0;
          res_found <= 1'b0;
          res_status <= STAT_OK;
        end
      endcase
    end

    if (cmd.emit) begin
      out_value <= res_value;
      out_found <= res_found;
      out_status <= res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.sweep) begin
        cnt <= cnt + 1'b1;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- src/lphm_ctrl.sv -----
`timescale 1ns / 1ps
// Controller state machine of the hash map: sequences probe, shift-back and sweep.
// Depends on lphm_pkg; drives the datapath through cmd_t and reads stat_t.
module lphm_ctrl import lphm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [10:0] {
    ST_INIT   = 11'b000_0000_0001,
    ST_IDLE   = 11'b000_0000_0010,
    ST_DECODE = 11'b000_0000_0100,
    ST_CLR    = 11'b000_0000_1000,
    ST_PREAD  = 11'b000_0001_0000,
    ST_PCHK   = 11'b000_0010_0000,
    ST_SREAD  = 11'b000_0100_0000,
    ST_SCHK   = 11'b000_1000_0000,
    ST_SHOME  = 11'b001_0000_0000,
    ST_SFIN   = 11'b010_0000_0000,
    ST_DONE   = 11'b100_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      ST_INIT, ST_CLR: begin
        cmd.wr_en = 1'b1;
        cmd.wsel = WS_SWEEP;
        cmd.sweep = 1'b1;
        if (stat.sweep_last) begin
          state_next = (state == ST_INIT) ? ST_IDLE : ST_DONE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (stat.op == ACT_CLEAR) begin
          state_next = ST_CLR;
        end else if (stat.op == ACT_WRITE && stat.reserved) begin
          cmd.finish = 1'b1;
          cmd.res_sel = RES_RESERVED;
          state_next = ST_DONE;
        end else begin
          cmd.probe_start = 1'b1;
          state_next = ST_PREAD;
        end
      end
      ST_PREAD: begin
        state_next = ST_PCHK;
      end
      ST_PCHK: begin
        if (stat.empty) begin
          cmd.finish = 1'b1;
          cmd.res_sel = RES_FREE;
          if (stat.op != ACT_REMOVE) begin
            cmd.wr_en = 1'b1;
            cmd.wsel = WS_INSERT;
          end
          state_next = ST_DONE;
        end else if (stat.match) begin
          cmd.finish = 1'b1;
          cmd.res_sel = RES_HIT;
          if (stat.op == ACT_REMOVE) begin
            cmd.shift_start = 1'b1;
            state_next = ST_SREAD;
          end else begin
            if (stat.op == ACT_WRITE) begin
              cmd.wr_en = 1'b1;
              cmd.wsel = WS_INSERT;
            end
            state_next = ST_DONE;
          end
        end else if (stat.last) begin
          cmd.finish = 1'b1;
          cmd.res_sel = RES_FULL;
          state_next = ST_DONE;
        end else begin
          cmd.probe_next = 1'b1;
          state_next = ST_PREAD;
        end
      end
      ST_SREAD: begin
        state_next = ST_SCHK;
      end
      ST_SCHK: begin
        if (stat.empty) begin
          state_next = ST_SFIN;
        end else begin
          cmd.shift_load = 1'b1;
          state_next = ST_SHOME;
        end
      end
      ST_SHOME: begin
        cmd.shift_eval = 1'b1;
        if (stat.move) begin
          cmd.wr_en = 1'b1;
          cmd.wsel = WS_MOVE;
        end
        if (stat.last) begin
          state_next = ST_SFIN;
        end else begin
          cmd.shift_next = 1'b1;
          state_next = ST_SREAD;
        end
      end
      ST_SFIN: begin
        cmd.wr_en = 1'b1;
        cmd.wsel = WS_VACATE;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- bench/lphm_map_checker.sv -----
`timescale 1ns / 1ps
// Checker for the hash map: watches the request, response and register ports, keeps its own
// copy of the slot store and size register, and compares every response with its prediction.
// Depends on lphm_pkg and lphm_ifs.
module lphm_map_checker import lphm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  lphm_req_if                req,
  lphm_rsp_if                rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  input  logic [31:0]        prdata,
  input  logic               pready,
  output int                 pending,
  output int                 mismatches
);

  localparam int SLOTS = 1 << LOG_SLOTS_MAX;
  localparam logic [PADDR_W-1:0] REG_SIZE_LOG = '0;

  typedef struct packed {
    logic [31:0] value;
    logic        found;
    status_t     status;
  } reply_t;

  typedef enum {LOOK_HIT, LOOK_FREE, LOOK_FULL} lookup_t;

  logic [31:0] key_store [SLOTS];
  logic [31:0] value_store [SLOTS];
  logic [3:0]  size_reg;
  reply_t      replies_due [$];
  int          fail_count;

  function automatic int home_of(logic [31:0] k, int lg);
    logic [31:0] prod;
    prod = k * HASH_MUL;
    return int'(prod >> (32 - lg));
  endfunction

  function automatic reply_t map_update(action_t act, logic [31:0] k, logic [31:0] d);
    reply_t  r;
    lookup_t outcome;
    int      lg, mask, idx, i, n, hole, shift_gap;
    r.value = '0;
    r.found = 1'b0;
    r.status = STAT_OK;
    lg = (size_reg < 1) ? 1 : ((size_reg > LOG_SLOTS_MAX) ? LOG_SLOTS_MAX : int'(size_reg));
    mask = (1 << lg) - 1;
    if (act == ACT_CLEAR) begin
      for (i = 0; i < SLOTS; i++) value_store[i] = EMPTY_VAL;
    end else if (act == ACT_WRITE && d == EMPTY_VAL) begin
      r.status = STAT_RESERVED;
    end else begin
      outcome = LOOK_FULL;
      idx = 0;
      i = home_of(k, lg) & mask;
      for (n = 0; n <= mask; n++) begin
        if (value_store[i] == EMPTY_VAL) begin
          outcome = LOOK_FREE;
          idx = i;
          break;
        end
        if (key_store[i] == k) begin
          outcome = LOOK_HIT;
          idx = i;
          break;
        end
        i = (i + 1) & mask;
      end
      r.found = (outcome == LOOK_HIT);
      if (act == ACT_REMOVE) begin
        if (outcome == LOOK_HIT) begin
          r.value = value_store[idx];
          // Backward shift: pull later entries of the cluster into the hole when their
          // home slot lies at or before it.
          hole = idx;
          shift_gap = 1;
          i = idx;
          for (n = 1; n <= mask; n++) begin
            i = (i + 1) & mask;
            if (value_store[i] == EMPTY_VAL) break;
            if (((i - home_of(key_store[i], lg)) & mask) >= shift_gap) begin
              key_store[hole] = key_store[i];
              value_store[hole] = value_store[i];
              hole = i;
              shift_gap = 1;
            end else begin
              shift_gap++;
            end
          end
          value_store[hole] = EMPTY_VAL;
        end else if (outcome == LOOK_FULL) begin
          r.status = STAT_FULL;
        end
      end else if (outcome == LOOK_FULL) begin
        r.status = STAT_FULL;
      end else begin
        if (outcome == LOOK_FREE) begin
          key_store[idx] = k;
          value_store[idx] = '0;
        end
        if (act == ACT_WRITE) value_store[idx] = d;
        r.value = value_store[idx];
      end
    end
    return r;
  endfunction

  task automatic note_failure(string what);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] mismatch %0d: %s", $realtime, fail_count, what);
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    mismatches = 0;
    size_reg = SIZE_LOG_RST;
  end

  always @(posedge clk) begin
    reply_t want, got;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        key_store[i] = '0;
        value_store[i] = EMPTY_VAL;
      end
      size_reg = SIZE_LOG_RST;
      replies_due.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        got.value = rsp.value;
        got.found = rsp.found;
        got.status = status_t'(rsp.status);
        if (replies_due.size() == 0) begin
          note_failure($sformatf("response value %h found %b status %0d with none due",
                                 got.value, got.found, got.status));
        end else begin
          want = replies_due.pop_front();
          if (got.value !== want.value || got.found !== want.found ||
              got.status !== want.status) begin
            note_failure($sformatf(
              "value %h/%h found %b/%b status %0d/%0d (expected/actual)",
              want.value, got.value, want.found, got.found, want.status, got.status));
          end
        end
      end
      if (req.valid && req.ready) begin
        replies_due.push_back(map_update(action_t'(req.action), req.key, req.data));
      end
      if (psel && penable && pready && paddr == REG_SIZE_LOG) begin
        if (pwrite) begin
          size_reg = pwdata[3:0];
        end else if (prdata !== {28'd0, size_reg}) begin
          note_failure($sformatf("size_log read %h/%h (expected/actual)",
                                 {28'd0, size_reg}, prdata));
        end
      end
    end
    pending <= replies_due.size();
    mismatches <= fail_count;
  end

endmodule

// ----- bench/tb_linear_probe_hash_map.sv -----
`timescale 1ns / 1ps
// Top of the hash map testbench: clock, reset, request and register stimulus, response stalls
// and the verdict. Depends on lphm_pkg, lphm_ifs, linear_probe_hash_map and lphm_map_checker.
module tb_linear_probe_hash_map;
  import lphm_pkg::*;

  localparam logic [PADDR_W-1:0] REG_SIZE_LOG = '0;
  localparam int SETTLE_CYCLES = 20;
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 160;
  localparam int HOLD_AFTER = 700;
  localparam int HOLD_CYCLES = 600;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  int                 pending;
  int                 mismatches;
  int                 reqs_taken;
  bit                 long_hold_done;

  logic [3:0]  phase_size [PHASES] = '{4'd2, 4'd1, 4'd3, 4'd5, 4'd4, 4'd12,
                                       4'd6, 4'd0, 4'd8, 4'd15, 4'd2, 4'd3};
  bit          phase_clear [PHASES] = '{1, 1, 0, 1, 1, 1, 0, 1, 1, 0, 1, 1};
  logic [31:0] key_pool [48];
  int          pool_n;

  lphm_req_if req_ch ();
  lphm_rsp_if rsp_ch ();

  linear_probe_hash_map i_dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  lphm_map_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .pending    (pending),
    .mismatches (mismatches)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      reqs_taken <= 0;
    end else if (req_ch.valid && req_ch.ready) begin
      reqs_taken <= reqs_taken + 1;
    end
  end

  task automatic offer(action_t act, logic [31:0] k, logic [31:0] d);
    req_ch.valid <= 1'b1;
    req_ch.action <= act;
    req_ch.key <= k;
    req_ch.data <= d;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic drain;
    req_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes size_log with random upper bits, then reads it back.
  task automatic program_size(logic [3:0] v);
    logic [31:0] w;
    w = $urandom;
    w[3:0] = v;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_SIZE_LOG;
    pwdata <= w;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic fill_pool(logic [3:0] v);
    int lg;
    lg = (v < 1) ? 1 : ((v > LOG_SLOTS_MAX) ? LOG_SLOTS_MAX : int'(v));
    pool_n = (1 << lg) + (1 << lg) / 2 + 1;
    if (pool_n > 48) pool_n = 48;
    for (int j = 0; j < pool_n; j++) key_pool[j] = $urandom;
    key_pool[0] = 32'hFFFF_FFFF;
    key_pool[1] = 32'h0;
  endtask

  task automatic send_random(int count);
    int          sent, burst, gap, r;
    action_t     act;
    logic [31:0] k, d;
    sent = 0;
    while (sent < count) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst = $urandom_range(1, 24);
      if (burst > count - sent) burst = count - sent;
      repeat (burst) begin
        r = $urandom_range(0, 999);
        if (r < 15) act = ACT_CLEAR;
        else if (r < 370) act = ACT_ACCESS;
        else if (r < 720) act = ACT_WRITE;
        else act = ACT_REMOVE;
        k = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, pool_n - 1)];
        case ($urandom_range(0, 49))
          0: d = EMPTY_VAL;
          1: d = 32'hFFFF_FFFE;
          2: d = 32'h0;
          default: d = $urandom;
        endcase
        offer(act, k, d);
        sent++;
      end
    end
  endtask

  // The response side stalls on its own pattern, with one long hold once the
  // request stream is well under way.
  initial begin
    rsp_ch.ready = 1'b0;
    long_hold_done = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!long_hold_done && reqs_taken >= HOLD_AFTER) begin
        long_hold_done = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      case ($urandom_range(0, 3))
        0: begin
          rsp_ch.ready <= 1'b1;
          repeat ($urandom_range(1, 40)) @(posedge clk);
        end
        1: begin
          repeat ($urandom_range(4, 30)) begin
            rsp_ch.ready <= $urandom_range(0, 1);
            @(posedge clk);
          end
        end
        2: begin
          rsp_ch.ready <= 1'b0;
          repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        default: begin
          repeat ($urandom_range(4, 30)) begin
            rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            @(posedge clk);
          end
        end
      endcase
    end
  end

  initial begin
    #10_000_000;
    $display("linear_probe_hash_map test failed");
    $finish;
  end

  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.action = ACT_ACCESS;
    req_ch.key = '0;
    req_ch.data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset size: inserts, hits, reserved write, removes, clear.
    offer(ACT_ACCESS, 32'h0, 32'h0);
    offer(ACT_ACCESS, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    offer(ACT_WRITE, 32'h0, 32'hFFFF_FFFE);
    offer(ACT_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    offer(ACT_WRITE, 32'h1234_5678, 32'h0);
    offer(ACT_ACCESS, 32'h0, $urandom);
    offer(ACT_REMOVE, 32'h0, $urandom);
    offer(ACT_REMOVE, 32'h0, $urandom);
    offer(ACT_REMOVE, 32'hFFFF_FFFF, $urandom);
    offer(ACT_CLEAR, $urandom, $urandom);
    drain();

    // Two slots: fill the table, then miss, write, remove on a full table, then remove one key and miss again.
    program_size(4'd1);
    offer(ACT_ACCESS, 32'd1, $urandom);
    offer(ACT_WRITE, 32'd2, $urandom);
    offer(ACT_ACCESS, 32'd3, $urandom);
    offer(ACT_WRITE, 32'd3, $urandom);
    offer(ACT_REMOVE, 32'd3, $urandom);
    offer(ACT_REMOVE, 32'd1, $urandom);
    offer(ACT_ACCESS, 32'd3, $urandom);
    drain();

    // Out-of-range sizes, with stale entries left in place.
    program_size(4'd0);
    offer(ACT_ACCESS, 32'd2, $urandom);
    offer(ACT_REMOVE, 32'd2, $urandom);
    drain();
    program_size(4'd15);
    offer(ACT_ACCESS, 32'd2, $urandom);
    offer(ACT_CLEAR, $urandom, $urandom);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      program_size(phase_size[p]);
      fill_pool(phase_size[p]);
      if (phase_clear[p]) offer(ACT_CLEAR, $urandom, $urandom);
      send_random(PHASE_ITEMS);
      drain();
    end

    repeat (50) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("linear_probe_hash_map test passed");
    end else begin
      $display("linear_probe_hash_map test failed");
    end
    $finish;
  end

endmodule

// ----- linear_probe_hash_map.f -----
src/lphm_pkg.sv
src/lphm_ifs.sv
src/lphm_ram.sv
src/lphm_dpath.sv
src/lphm_ctrl.sv
src/linear_probe_hash_map.sv
bench/lphm_map_checker.sv
bench/tb_linear_probe_hash_map.sv
